@@ hw/rtl/mcrs_pkg.sv @@
// Package for the row statistics scan unit: widths, codes, state enum, records.
// No dependencies.
`default_nettype none
package mcrs_pkg;
    localparam int MAX_SLOTS_DEF     = 1024;
    localparam int FRACTION_BITS_DEF = 31;
    localparam int COL_W    = 11;
    localparam int CNT_W    = 64;
    localparam int RAYS_W   = 48;
    localparam int SCALE_W  = 48;
    localparam int THR_W    = 31;
    localparam int ERR_W    = 31;
    localparam int FAC_W    = 32;
    localparam int ENTRY_W  = 40;
    localparam int ADDR_W   = 6;

    localparam logic [2:0] REG_REAL_COLS = 3'd0;
    localparam logic [2:0] REG_LOST_COL  = 3'd1;
    localparam logic [2:0] REG_INV_SCALE = 3'd2;
    localparam logic [2:0] REG_KEEP_THR  = 3'd3;
    localparam logic [2:0] REG_KEEP_FULL = 3'd4;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_ENERGY, S_FDIV, S_FACT, S_EMUL, S_EDIV, S_SQRT, S_STATS,
        S_ENTRY, S_RAYS, S_MDIV, S_LDIV, S_SUM, S_OUT
    } t_state;

    // Start/done handshake to a serial unit.
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

    typedef struct packed {
        logic        kind;
        logic [10:0] column;
        logic [31:0] factor;
        logic [30:0] mean_error;
        logic [30:0] peak_error;
        logic [31:0] lost_fraction;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

@@ hw/rtl/mcrs_if.sv @@
// Valid/ready stream interfaces for the input and result channels.
// Depends on mcrs_pkg.
`default_nettype none
interface mcrs_in_if;
    import mcrs_pkg::*;
    logic              valid;
    logic              ready;
    logic              cell_present;
    logic [COL_W-1:0]  cell_column;
    logic [CNT_W-1:0]  cell_count;
    logic [RAYS_W-1:0] row_rays;
    logic              row_end;
    logic              matrix_end;
    modport source (output valid, cell_present, cell_column, cell_count, row_rays,
                    row_end, matrix_end, input ready);
    modport sink (input valid, cell_present, cell_column, cell_count, row_rays,
                  row_end, matrix_end, output ready);
endinterface

interface mcrs_out_if;
    import mcrs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic [COL_W-1:0]        entry_column;
    logic signed [FAC_W-1:0] entry_factor;
    logic [ERR_W-1:0]        mean_error;
    logic [ERR_W-1:0]        peak_error;
    logic signed [FAC_W-1:0] lost_fraction;
    logic                    last_result;
    modport source (output valid, result_kind, entry_column, entry_factor, mean_error,
                    peak_error, lost_fraction, last_result, input ready);
    modport sink (input valid, result_kind, entry_column, entry_factor, mean_error,
                  peak_error, lost_fraction, last_result, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/monte_carlo_row_stats_scan_unit.sv @@
// Top level of the row statistics scan: sequencer, statistics, APB registers.
// Depends on mcrs_pkg, mcrs_if, mcrs_mul, mcrs_div, mcrs_sqrt.
//
//  channel   dir   kind      payload
//  in_ch     in    valid/rdy cell_present, cell_column, cell_count, row_rays, ends
//  out_ch    out   valid/rdy kind, column, factor, mean/peak error, lost_fraction
//  apb       in    APB       five registers at 8*i, 64-bit data
//
// One transaction at a time. A cell uses a shift-add multiply, a quotient, and,
// for a real column with a factor in range, a second multiply, a second quotient
// and a root. A matrix end adds two divides. Items with nothing to do skip the
// serial units.
// Reset is synchronous, active low; no clearing pass. Results wait in one
// register until taken; the sequencer stalls on a full result register.
`default_nettype none
module monte_carlo_row_stats_scan_unit #(
    parameter int MAX_SLOTS     = mcrs_pkg::MAX_SLOTS_DEF,
    parameter int FRACTION_BITS = mcrs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mcrs_in_if.sink                          in_ch,
    mcrs_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mcrs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);
    import mcrs_pkg::*;

    // registers
    logic [COL_W-1:0]   r_real_cols, r_lost_col;
    logic [SCALE_W-1:0] r_inv_scale;
    logic [THR_W-1:0]   r_keep_thr;
    logic               r_keep_full;
    logic [2:0]         reg_idx;
    logic               wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_cols <= COL_W'(1);
            r_lost_col  <= COL_W'(1);
            r_inv_scale <= '0;
            r_keep_thr  <= '0;
            r_keep_full <= 1'b0;
        end else if (wr && paddr[2:0] == 3'd0) begin
            unique case (reg_idx)
                REG_REAL_COLS: r_real_cols <= pwdata[COL_W-1:0];
                REG_LOST_COL:  r_lost_col  <= pwdata[COL_W-1:0];
                REG_INV_SCALE: r_inv_scale <= pwdata[SCALE_W-1:0];
                REG_KEEP_THR:  r_keep_thr  <= pwdata[THR_W-1:0];
                REG_KEEP_FULL: r_keep_full <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_REAL_COLS: prdata = 64'(r_real_cols);
            REG_LOST_COL:  prdata = 64'(r_lost_col);
            REG_INV_SCALE: prdata = 64'(r_inv_scale);
            REG_KEEP_THR:  prdata = 64'(r_keep_thr);
            REG_KEEP_FULL: prdata = 64'(r_keep_full);
            default:       prdata = '0;
        endcase
    end

    // statistics state
    logic [63:0]        r_err_total, r_rays_total;
    logic [31:0]        r_err_peak;
    logic [ENTRY_W-1:0] r_entry_total;
    logic signed [63:0] r_lost_total;

    // captured item and working values
    logic [COL_W-1:0]  r_col;
    logic [63:0]       r_cell;
    logic [RAYS_W-1:0] r_rays;
    logic              r_rend, r_mend, r_lost, r_neg, r_emit, r_cell_ok;
    logic [63:0]       r_energy;
    logic [127:0]      r_fq;
    logic [63:0]       r_mean;
    logic              r_lneg;

    t_state r_state, n_state;

    // output holding register
    t_result r_res;
    logic    r_res_v;

    // serial units
    t_unit_ctl mul_ctl, div_ctl, sqrt_ctl;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic [127:0] mul_p;
    logic         mul_done, div_done, sqrt_done;
    logic [127:0] div_n, div_q;
    logic [63:0]  div_d, sqrt_root;

    mcrs_mul #(.AW(64), .BW(64)) u_mul (
        .i_clk, .i_rst_n, .i_ctl(mul_ctl), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_p(mul_p));
    mcrs_div u_div (
        .i_clk, .i_rst_n, .i_ctl(div_ctl), .i_n(div_n), .i_d(div_d),
        .o_done(div_done), .o_q(div_q));
    mcrs_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_ctl(sqrt_ctl), .i_v(div_q),
        .o_done(sqrt_done), .o_root(sqrt_root));

    localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

    // scale a magnitude by 2^FRACTION_BITS / 2^32, fraction bits dropped
    function automatic logic [127:0] frac_num(input logic [63:0] m);
        logic [191:0] t;
        t = {64'd0, m, 64'd0} << FRACTION_BITS;
        return {32'd0, t[191:96]};
    endfunction

    function automatic logic [31:0] sat32(input logic [127:0] mag, input logic neg);
        logic [127:0] lim;
        logic [31:0]  m;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        m   = (mag > lim) ? lim[31:0] : mag[31:0];
        return neg ? 32'(-m) : m;
    endfunction

    logic [63:0]  cell_mag;
    logic [111:0] shifted;
    logic [63:0]  energy_n;
    logic [COL_W-1:0] slots;
    logic         is_real, err_ok;
    logic [63:0]  err_cur;
    logic [63:0]  lt_mag;
    logic signed [64:0] lsum;
    logic [64:0]  esum, rsum;

    always_comb begin
        cell_mag = (r_lost && r_cell[63]) ? 64'(-r_cell) : r_cell;
        shifted  = mul_p[127:16];
        energy_n = (shifted[111:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : shifted[63:0];
        slots    = (32'(r_real_cols) > MAX_SLOTS) ? COL_W'(MAX_SLOTS) : r_real_cols;
        is_real  = r_col < slots;
        err_ok   = !r_neg && r_fq[127:64] == '0 && r_fq[63:0] != '0 && r_fq[63:0] < ONE;
        // root is final whenever the stats update fires on the error path
        err_cur  = (is_real && err_ok) ? sqrt_root : 64'd0;
        lt_mag   = r_lost_total[63] ? 64'(-r_lost_total) : 64'(r_lost_total);
        lsum     = 65'(r_lost_total) + (r_neg ? -65'(r_energy) : 65'(r_energy));
        esum     = 65'(r_err_total) + 65'(err_cur);
        rsum     = 65'(r_rays_total) + 65'(r_rays);
    end

    assign in_ch.ready = (r_state == S_IDLE);

    // next state and unit controls
    always_comb begin
        n_state        = r_state;
        mul_ctl.start  = 1'b0;
        div_ctl.start  = 1'b0;
        sqrt_ctl.start = 1'b0;
        mul_ctl.done   = mul_done;
        div_ctl.done   = div_done;
        sqrt_ctl.done  = sqrt_done;
        mul_a          = 64'(cell_mag);
        mul_b          = 64'(r_inv_scale);
        div_n          = frac_num(r_energy);
        div_d          = 64'(r_rays);
        unique case (r_state)
            S_IDLE: if (in_ch.valid) n_state = S_MUL;
            S_MUL: begin
                if (r_cell_ok) begin
                    mul_ctl.start = 1'b1;
                    n_state = S_ENERGY;
                end else begin
                    n_state = S_RAYS;
                end
            end
            S_ENERGY: if (mul_done) n_state = S_FDIV;
            S_FDIV: begin
                div_ctl.start = 1'b1;
                n_state = S_FACT;
            end
            S_FACT: if (div_done) n_state = S_EMUL;
            S_EMUL: begin
                if (is_real && err_ok) begin
                    mul_a = r_fq[63:0];
                    mul_b = ONE - r_fq[63:0];
                    mul_ctl.start = 1'b1;
                    n_state = S_EDIV;
                end else begin
                    n_state = S_STATS;
                end
            end
            S_EDIV: if (mul_done) begin
                div_n = mul_p;
                div_ctl.start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: if (div_done) begin
                sqrt_ctl.start = 1'b1;
                n_state = S_STATS;
            end
            S_STATS: if (!(is_real && err_ok) || sqrt_done) n_state = S_ENTRY;
            S_ENTRY: if (!r_res_v || !r_emit) n_state = S_RAYS;
            S_RAYS:  n_state = r_mend ? S_MDIV : S_IDLE;
            S_MDIV: begin
                div_n = {64'd0, r_err_total};
                div_d = (r_entry_total == '0) ? 64'd1 : 64'(r_entry_total);
                div_ctl.start = 1'b1;
                n_state = S_LDIV;
            end
            S_LDIV: if (div_done) begin
                div_n = frac_num(lt_mag);
                div_d = (r_rays_total == '0) ? 64'd1 : r_rays_total;
                div_ctl.start = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: if (div_done) n_state = S_OUT;
            S_OUT: if (!r_res_v) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    logic out_take;
    assign out_take = out_ch.valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_total   <= '0;
            r_err_peak    <= '0;
            r_entry_total <= '0;
            r_lost_total  <= '0;
            r_rays_total  <= '0;
            r_res_v       <= 1'b0;
        end else begin
            if (out_take) r_res_v <= 1'b0;
            unique case (r_state)
                S_STATS: if (n_state == S_ENTRY) begin
                    if (r_lost) begin
                        if (lsum[64] != lsum[63])
                            r_lost_total <= lsum[64] ? 64'sh8000_0000_0000_0000
                                                     : 64'sh7FFF_FFFF_FFFF_FFFF;
                        else
                            r_lost_total <= lsum[63:0];
                    end
                    if (is_real) begin
                        r_err_total <= esum[64] ? '1 : esum[63:0];
                        if (err_cur > 64'(r_err_peak))
                            r_err_peak <= (err_cur > 64'hFFFF_FFFF) ? '1 : err_cur[31:0];
                        if (r_entry_total != '1) r_entry_total <= r_entry_total + 1'b1;
                    end
                end
                S_ENTRY: if (r_emit && !r_res_v) begin
                    r_res_v <= 1'b1;
                end
                S_RAYS: if (r_rend || r_mend) begin
                    r_rays_total <= rsum[64] ? '1 : rsum[63:0];
                end
                S_OUT: if (!r_res_v) begin
                    r_res_v       <= 1'b1;
                    r_err_total   <= '0;
                    r_err_peak    <= '0;
                    r_entry_total <= '0;
                    r_lost_total  <= '0;
                    r_rays_total  <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath captures, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (in_ch.valid) begin
                r_col     <= in_ch.cell_column;
                r_cell    <= in_ch.cell_count;
                r_rays    <= in_ch.row_rays;
                r_rend    <= in_ch.row_end;
                r_mend    <= in_ch.matrix_end;
                r_lost    <= in_ch.cell_column == r_lost_col;
                r_cell_ok <= in_ch.cell_present && in_ch.row_rays != '0
                             && r_inv_scale != '0;
                r_emit    <= 1'b0;
            end
            S_ENERGY: if (mul_done) begin
                r_energy <= energy_n;
                r_neg    <= r_lost && r_cell[63] && energy_n != '0;
            end
            S_FACT: if (div_done) begin
                r_fq   <= div_q;
                r_emit <= r_keep_full && (div_q > 128'(r_keep_thr));
            end
            S_LDIV: if (div_done) begin
                r_mean <= div_q[63:0];
                r_lneg <= r_lost_total[63];
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_ENTRY && r_emit && !r_res_v) begin
            r_res.kind          <= KIND_ENTRY;
            r_res.column        <= r_col;
            r_res.factor        <= sat32(r_fq, r_neg);
            r_res.mean_error    <= '0;
            r_res.peak_error    <= '0;
            r_res.lost_fraction <= '0;
            r_res.last          <= !r_mend;
        end else if (r_state == S_OUT && !r_res_v) begin
            r_res.kind          <= KIND_SUMMARY;
            r_res.column        <= '0;
            r_res.factor        <= '0;
            r_res.mean_error    <= (r_entry_total == '0) ? '0 :
                                   (r_mean > 64'h7FFF_FFFF) ? '1 : r_mean[30:0];
            r_res.peak_error    <= (r_err_peak > 32'h7FFF_FFFF) ? '1 : r_err_peak[30:0];
            r_res.lost_fraction <= (r_rays_total == '0 || r_lost_total == '0) ? '0 :
                                   sat32(div_q, r_lneg);
            r_res.last          <= 1'b1;
        end
    end

    assign out_ch.valid         = r_res_v;
    assign out_ch.result_kind   = r_res.kind;
    assign out_ch.entry_column  = r_res.column;
    assign out_ch.entry_factor  = r_res.factor;
    assign out_ch.mean_error    = r_res.mean_error;
    assign out_ch.peak_error    = r_res.peak_error;
    assign out_ch.lost_fraction = r_res.lost_fraction;
    assign out_ch.last_result   = r_res.last;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !mul_ctl.done && !div_ctl.done && !sqrt_ctl.done)
        else $error("unit finished while idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r_res))
        else $error("pending result changed");
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.result_kind == KIND_SUMMARY |-> out_ch.last_result)
        else $error("summary not last");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !r_res_v |=> r_entry_total == '0 && r_rays_total == '0)
        else $error("state not cleared after summary");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/mcrs_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on mcrs_pkg.
`default_nettype none
module mcrs_mul #(
    parameter int AW = 64,
    parameter int BW = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mcrs_pkg::t_unit_ctl    i_ctl,
    input  wire logic [AW-1:0]          i_a,
    input  wire logic [BW-1:0]          i_b,
    output logic                        o_done,
    output logic [AW+BW-1:0]            o_p
);
    import mcrs_pkg::*;
    localparam int CW = $clog2(BW + 1);
    logic [AW+BW-1:0] r_p, r_a;
    logic [BW-1:0]    r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_p <= '0;
            r_a <= {{BW{1'b0}}, i_a};
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) r_p <= r_p + r_a;
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

@@ hw/rtl/mcrs_div.sv @@
// Restoring divider, one quotient bit per cycle, 128-bit dividend, 64-bit divisor.
// Depends on mcrs_pkg.
`default_nettype none
module mcrs_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mcrs_pkg::t_unit_ctl i_ctl,
    input  wire logic [127:0]        i_n,
    input  wire logic [63:0]         i_d,
    output logic                     o_done,
    output logic [127:0]             o_q
);
    import mcrs_pkg::*;
    logic [127:0] r_q;
    logic [63:0]  r_r, r_d;
    logic [7:0]   r_cnt;
    logic         r_busy, r_done;
    logic [64:0]  sh;
    logic         take;

    always_comb begin
        sh   = {r_r, r_q[127]};
        take = sh[64] || (sh[63:0] >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd128;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q <= i_n;
            r_r <= '0;
            r_d <= i_d;
        end else if (r_busy) begin
            r_r <= take ? 64'(sh - {1'b0, r_d}) : sh[63:0];
            r_q <= {r_q[126:0], take};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

@@ hw/rtl/mcrs_sqrt.sv @@
// Bit-serial integer square root of a 128-bit value, one result bit per cycle.
// Depends on mcrs_pkg.
`default_nettype none
module mcrs_sqrt (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mcrs_pkg::t_unit_ctl i_ctl,
    input  wire logic [127:0]        i_v,
    output logic                     o_done,
    output logic [63:0]              o_root
);
    import mcrs_pkg::*;
    logic [127:0] r_v;
    logic [65:0]  r_rem;
    logic [63:0]  r_root;
    logic [6:0]   r_cnt;
    logic         r_busy, r_done;
    logic [65:0]  trial, sh;

    always_comb begin
        sh    = {r_rem[63:0], r_v[127:126]};
        trial = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // two radicand bits per step; remainder stays below 2*root+1
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v <= r_v << 2;
            if (sh >= trial) begin
                r_rem  <= sh - trial;
                r_root <= {r_root[62:0], 1'b1};
            end else begin
                r_rem  <= sh;
                r_root <= {r_root[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire
